FILE: hw/rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; imported by every module of the block.
package sem_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MIN_DIM      = 3;
    localparam int SAT_LIMIT    = 255;

    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);   // column counter / line store address
    localparam int ROW_W  = 12;
    localparam int FW_W   = 11;                  // frame_width register
    localparam int FH_W   = 13;                  // frame_height register
    localparam int CFG_W  = 13;                  // widest register
    localparam int SUM_W  = 10;                  // weighted column/row sum, max 4*255
    localparam int MAG_W  = 11;                  // |Gx| + |Gy|, max 2040

    // Register indexes on the configuration port
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // 3x3 neighbourhood: t = top row, m = middle, b = bottom; 0 = left column
    typedef struct packed {
        logic [PIX_W-1:0] t0, m0, b0;
        logic [PIX_W-1:0] t1, m1, b1;
        logic [PIX_W-1:0] t2, m2, b2;
    } t_win;

    // Position tags carried with each result
    typedef struct packed {
        logic             interior;
        logic [ROW_W-1:0] row;
        logic [9:0]       column;
        logic             frame_end;
    } t_tag;

endpackage

FILE: hw/rtl/sem_line_buf.sv
// Two line stores packed side by side in one memory: {upper, lower} per column.
// Depends on sem_pkg.
module sem_line_buf
    import sem_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [COL_W-1:0]   i_waddr,
    input  logic [2*PIX_W-1:0] i_wdata,
    input  logic [COL_W-1:0]   i_raddr,
    output logic [2*PIX_W-1:0] o_rdata
);

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sem_front.sv
// Raster position counters, frame size registers, window registers and line stores.
// Assembles the 3x3 window and position tags of the item being accepted.
// Depends on sem_pkg and sem_line_buf.
module sem_front
    import sem_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_acc,
    input  logic [PIX_W-1:0] i_pixel,
    output t_win             o_win,
    output t_tag             o_tag
);

    localparam logic [FW_W-1:0] W_MIN = FW_W'(MIN_DIM);
    localparam logic [FW_W-1:0] W_MAX = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] H_MIN = FH_W'(MIN_DIM);
    localparam logic [FH_W-1:0] H_MAX = FH_W'(HEIGHT_LIMIT);

    logic [FW_W-1:0]  r_width;
    logic [FH_W-1:0]  r_height;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_win [6];

    logic [FW_W-1:0]    w_eff;
    logic [FH_W-1:0]    h_eff;
    logic               col_last, row_last;
    logic [2*PIX_W-1:0] lb_rdata;
    logic [PIX_W-1:0]   t2, m2;

    always_comb begin
        w_eff = r_width;
        if (r_width < W_MIN) w_eff = W_MIN;
        else if (r_width > W_MAX) w_eff = W_MAX;
        h_eff = r_height;
        if (r_height < H_MIN) h_eff = H_MIN;
        else if (r_height > H_MAX) h_eff = H_MAX;
    end

    assign col_last = (FW_W'(r_col) + 1'b1) >= w_eff;
    assign row_last = (FH_W'(r_row) + 1'b1) >= h_eff;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (i_acc) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= FW_W'(MAX_WIDTH);
            r_height <= FH_W'(1024);
            r_col    <= '0;
            r_row    <= '0;
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT: r_height <= i_cfg_data[FH_W-1:0];
                    default: ;
                endcase
            end
            if (i_acc) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= t2;
                r_win[4] <= m2;
                r_win[5] <= i_pixel;
            end
        end
    end

    // Read address runs one item ahead so data is ready when the pixel arrives
    sem_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_we    (i_acc),
        .i_waddr (r_col),
        .i_wdata ({m2, i_pixel}),
        .i_raddr (n_col),
        .o_rdata (lb_rdata)
    );

    assign t2 = lb_rdata[2*PIX_W-1:PIX_W];
    assign m2 = lb_rdata[PIX_W-1:0];

    always_comb begin
        o_win.t0 = r_win[0];
        o_win.m0 = r_win[1];
        o_win.b0 = r_win[2];
        o_win.t1 = r_win[3];
        o_win.m1 = r_win[4];
        o_win.b1 = r_win[5];
        o_win.t2 = t2;
        o_win.m2 = m2;
        o_win.b2 = i_pixel;
        o_tag.interior  = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
        o_tag.row       = r_row - 1'b1;
        o_tag.column    = 10'(r_col - 1'b1);
        o_tag.frame_end = row_last && col_last;
    end

endmodule

FILE: hw/rtl/sem_grad.sv
// Sobel X/Y gradients of a 3x3 window, L1 magnitude saturated at 255.
// Depends on sem_pkg.
module sem_grad
    import sem_pkg::*;
(
    input  t_win             i_win,
    output logic [PIX_W-1:0] o_mag
);

    logic [SUM_W-1:0] left, right, top, bottom;
    logic [SUM_W-1:0] abs_x, abs_y;
    logic [MAG_W-1:0] sum;

    always_comb begin
        left   = SUM_W'(i_win.t0) + SUM_W'({i_win.m0, 1'b0}) + SUM_W'(i_win.b0);
        right  = SUM_W'(i_win.t2) + SUM_W'({i_win.m2, 1'b0}) + SUM_W'(i_win.b2);
        top    = SUM_W'(i_win.t0) + SUM_W'({i_win.t1, 1'b0}) + SUM_W'(i_win.t2);
        bottom = SUM_W'(i_win.b0) + SUM_W'({i_win.b1, 1'b0}) + SUM_W'(i_win.b2);
        abs_x  = (right >= left) ? right - left : left - right;
        abs_y  = (top >= bottom) ? top - bottom : bottom - top;
        sum    = MAG_W'(abs_x) + MAG_W'(abs_y);
        o_mag  = (sum > MAG_W'(SAT_LIMIT)) ? PIX_W'(SAT_LIMIT) : sum[PIX_W-1:0];
    end

endmodule

FILE: hw/rtl/sobel_edge_magnitude_top.sv
// Top level of the Sobel 3x3 edge magnitude block.
// Depends on sem_pkg, sem_front and sem_grad.
//
// Usage
//  - Input channel (i_valid / o_ready / i_pixel): 8-bit grey pixels in raster
//    order, one item per cycle at full rate while o_ready stays high.
//  - Output channel (o_valid / i_ready): one item per interior pixel with its
//    magnitude min(|Gx|+|Gy|, 255), row, column and a frame_end mark on the
//    last interior result. Border pixels produce nothing; fill them with zero.
//  - Config port (i_cfg_we / i_cfg_index / i_cfg_data): 0 = frame_width,
//    1 = frame_height; values are clamped to 3..1024 and 3..4096 in use. A
//    write restarts the frame at row 0, column 0. Write only while idle.
//  - Path: a result passes through the window register, then the output register,
//    to o_valid. Throughput is one item per cycle while the receiver does not stall,
//    set by the registered line store read that runs one column ahead.
//  - Reset (synchronous, active low) clears counters, window and valids;
//    frame size returns to 1024 x 1024. Line stores are not cleared: the first
//    two rows of every frame fill them before any read is used.
//  - Receiver stall: the output register holds its item; the window stage can
//    still take one more item, after which o_ready drops until space frees.
module sobel_edge_magnitude_top
    import sem_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    // pixel in
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel,
    // result out
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_magnitude,
    output logic [ROW_W-1:0] o_row,
    output logic [9:0]       o_column,
    output logic             o_frame_end
);

    t_win win;
    t_tag tag;
    logic in_acc, out_free, s1_adv;
    logic [PIX_W-1:0] mag;

    // window stage
    logic             r_s1_valid;
    t_win             r_s1_win;
    t_tag             r_s1_tag;

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_mag;
    t_tag             r_out_tag;

    assign out_free = !r_out_valid || i_ready;
    assign s1_adv   = r_s1_valid && out_free;
    assign o_ready  = !r_s1_valid || out_free;
    assign in_acc   = i_valid && o_ready;

    sem_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (in_acc),
        .i_pixel     (i_pixel),
        .o_win       (win),
        .o_tag       (tag)
    );

    sem_grad u_grad (
        .i_win (r_s1_win),
        .o_mag (mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= tag.interior;   // border items stop here
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_win <= win;
            r_s1_tag <= tag;
        end
        if (s1_adv) begin
            r_out_mag <= mag;
            r_out_tag <= r_s1_tag;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_magnitude = r_out_mag;
    assign o_row       = r_out_tag.row;
    assign o_column    = r_out_tag.column;
    assign o_frame_end = r_out_tag.frame_end;

endmodule

FILE: dv/sobel_edge_magnitude_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for sobel_edge_magnitude_top: streams pixel frames and compares
// every edge result against a cycle-free predictor of the 3x3 Sobel L1 magnitude.
// Depends on sem_pkg and the block's RTL only.
module sobel_edge_magnitude_top_test;
    import sem_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES  = 8;     // margin over the block's window and output registers
    localparam int RANDOM_PIXELS = 1530;

    // hand-built frames at 3x3: saturating step, unsaturated negative gradient, then
    // three pixels of a third frame to show the counters wrapped
    localparam logic [PIX_W-1:0] DIRECTED_PIX [21] = '{
        8'd0,   8'd0,   8'd255, 8'd0,  8'd0,  8'd255, 8'd0,  8'd0,  8'd255,
        8'd30,  8'd20,  8'd10,  8'd60, 8'd20, 8'd10,  8'd30, 8'd20, 8'd10,
        8'd255, 8'd128, 8'd1
    };

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic [ROW_W-1:0] row;
        logic [9:0]       column;
        logic             frame_end;
    } t_edge_result;

    // ---------------------------------------------------------------- DUT ports
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic             i_cfg_index = 1'b0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_valid     = 1'b0;
    logic             o_ready;
    logic [PIX_W-1:0] i_pixel     = '0;
    logic             o_valid;
    logic             i_ready     = 1'b0;
    logic [PIX_W-1:0] o_magnitude;
    logic [ROW_W-1:0] o_row;
    logic [9:0]       o_column;
    logic             o_frame_end;

    sobel_edge_magnitude_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_magnitude (o_magnitude),
        .o_row       (o_row),
        .o_column    (o_column),
        .o_frame_end (o_frame_end)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------ predictor state
    // Own copy of the frame size registers, line stores, window and raster position.
    // Line store entries start unknown; each frame writes rows 0 and 1 before use.
    logic [FW_W-1:0]  width_reg  = FW_W'(1024);
    logic [FH_W-1:0]  height_reg = FH_W'(1024);
    logic [PIX_W-1:0] line_upper [MAX_WIDTH];
    logic [PIX_W-1:0] line_lower [MAX_WIDTH];
    logic [PIX_W-1:0] win_q [6] = '{default: '0};
    int               col_pos = 0;
    int               row_pos = 0;

    t_edge_result     results_due [$];    // edge results owed by the block, oldest first
    logic [PIX_W-1:0] pixels_to_send [$]; // pixels waiting for the input driver

    // bench control and bookkeeping
    int  idle_pct = 0;       // chance (percent) of starting an idle burst
    bit  calm = 1'b0;        // closing stretch: no idling on either side
    int  in_gap = 0;
    int  out_hold = 0;
    bit  pix_took = 1'b0;    // pixel item taken at the last rising edge
    bit  res_took = 1'b0;    // result item taken at the last rising edge
    int  quiet_cycles = 0;
    int  mismatches = 0;
    int  pixels_taken = 0;
    int  results_seen = 0;
    int  frames_ended = 0;
    int  scene_level = 128;  // slowly drifting grey level for smooth picture areas

    // Frame dimension as the block uses it: clamped to [MIN_DIM, hi].
    function automatic int dim_in_use(input int v, input int hi);
        return (v < MIN_DIM) ? MIN_DIM : ((v > hi) ? hi : v);
    endfunction

    // Register write: new size, and the raster restarts at row 0, column 0.
    // Line stores and window keep whatever they hold.
    function automatic void apply_frame_reg(input logic idx, input logic [CFG_W-1:0] val);
        if (idx == CFG_FRAME_WIDTH) begin
            width_reg = val[FW_W-1:0];
        end else begin
            height_reg = val[FH_W-1:0];
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    // One pixel into the window. Once the pixel sits at row >= 2 and column >= 2 the
    // neighbourhood of the pixel one up and one left is complete and a result is owed.
    function automatic void sobel_step(input logic [PIX_W-1:0] pix);
        int w, h, gx, gy, mag;
        logic [PIX_W-1:0] t0, m0, b0, t1, m1, b1, t2, m2;
        t_edge_result res;
        w  = dim_in_use(int'(width_reg), MAX_WIDTH);
        h  = dim_in_use(int'(height_reg), HEIGHT_LIMIT);
        t2 = line_upper[col_pos];
        m2 = line_lower[col_pos];
        t0 = win_q[0];
        m0 = win_q[1];
        b0 = win_q[2];
        t1 = win_q[3];
        m1 = win_q[4];
        b1 = win_q[5];
        if (row_pos >= 2 && col_pos >= 2) begin
            gx = (int'(t2) + 2 * int'(m2) + int'(pix)) - (int'(t0) + 2 * int'(m0) + int'(b0));
            gy = (int'(t0) + 2 * int'(t1) + int'(t2)) - (int'(b0) + 2 * int'(b1) + int'(pix));
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (mag > SAT_LIMIT) mag = SAT_LIMIT;
            res.magnitude = PIX_W'(mag);
            res.row       = ROW_W'(row_pos - 1);
            res.column    = 10'(col_pos - 1);
            res.frame_end = (row_pos + 1 >= h) && (col_pos + 1 >= w);
            results_due.push_back(res);
        end
        line_upper[col_pos] = m2;
        line_lower[col_pos] = pix;
        win_q[0] = t1;
        win_q[1] = m1;
        win_q[2] = b1;
        win_q[3] = t2;
        win_q[4] = m2;
        win_q[5] = pix;
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    // Picture content: mostly smooth areas (unsaturated gradients), some noise and
    // some hard black/white edges.
    function automatic logic [PIX_W-1:0] scene_pixel();
        int sel, v;
        sel = $urandom_range(0, 9);
        if (sel < 3) return PIX_W'($urandom_range(0, 255));
        if (sel == 3) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        scene_level = scene_level + int'($urandom_range(0, 8)) - 4;
        if (scene_level < 0) scene_level = 0;
        if (scene_level > 255) scene_level = 255;
        v = scene_level + int'($urandom_range(0, 6)) - 3;
        v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
        return PIX_W'(v);
    endfunction

    // ------------------------------------------------------------ pixel driver
    // Changes only at the falling edge; a new item goes up once the last one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || pix_took) begin
            if (in_gap > 0) begin
                in_gap--;
                i_valid <= 1'b0;
            end else if (pixels_to_send.size() > 0) begin
                i_valid <= 1'b1;
                i_pixel <= pixels_to_send.pop_front();
                if (!calm && $urandom_range(0, 99) < idle_pct) in_gap = $urandom_range(1, 10);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------- result sink
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < idle_pct) out_hold = $urandom_range(1, 10);
        end
    end

    // --------------------------------------------- monitor, checker, watchdog
    // Results are checked before the pixel of the same edge is predicted, so a result
    // can never be matched against an expectation raised at the same edge.
    always @(posedge i_clk) begin
        t_edge_result seen, want;
        pix_took = i_rst_n && i_valid && o_ready;
        res_took = i_rst_n && o_valid && i_ready;
        if (res_took) begin
            seen = {o_magnitude, o_row, o_column, o_frame_end};
            results_seen++;
            if (o_frame_end) frames_ended++;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result mag %0d row %0d col %0d end %0b",
                             $time, seen.magnitude, seen.row, seen.column, seen.frame_end);
            end else begin
                want = results_due.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result mismatch, expected mag %0d row %0d col %0d ",
                                  "end %0b, got mag %0d row %0d col %0d end %0b"},
                                 $time, want.magnitude, want.row, want.column,
                                 want.frame_end, seen.magnitude, seen.row, seen.column,
                                 seen.frame_end);
                end
            end
        end
        if (pix_took) begin
            sobel_step(i_pixel);
            pixels_taken++;
        end
        if (pix_took || res_took) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, results_due.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------- sequencing
    // Idle means: every pixel taken and every owed result delivered. Sampled at the
    // rising edge where the queues and valid are stable, then a drain for latency.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixels_to_send.size() != 0 || i_valid || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        apply_frame_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Optional register writes at idle, then whole frames of picture plus an optional
    // tail of extra pixels that need not end on a frame boundary.
    task automatic run_phase(input bit do_w, input logic [CFG_W-1:0] wval,
                             input bit do_h, input logic [CFG_W-1:0] hval,
                             input int frames, input int extra, output int n);
        wait_idle();
        if (do_w) write_reg(CFG_FRAME_WIDTH, wval);
        if (do_h) write_reg(CFG_FRAME_HEIGHT, hval);
        n = dim_in_use(int'(width_reg), MAX_WIDTH)
            * dim_in_use(int'(height_reg), HEIGHT_LIMIT) * frames + extra;
        repeat (n) pixels_to_send.push_back(scene_pixel());
    endtask

    initial begin
        int n, w, h, frames, extra, sent;
        bit do_w, do_h, first;
        logic [CFG_W-1:0] wval;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Width 0 and height 1 both clamp up to 3: hand-built 3x3 frames.
        idle_pct = 10;
        run_phase(1'b1, 13'd0, 1'b1, 13'd1, 0, 0, n);
        foreach (DIRECTED_PIX[i]) pixels_to_send.push_back(DIRECTED_PIX[i]);

        // Random small frames, sizes sometimes out of range, sometimes only one
        // register rewritten, sometimes cut short mid-frame.
        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_PIXELS) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 5;
                default: idle_pct = 20;
            endcase
            do_w   = first || ($urandom_range(0, 5) != 0);
            do_h   = first || ($urandom_range(0, 5) != 0);
            w      = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(3, 10);
            h      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(3, 7);
            wval   = {2'($urandom_range(0, 3)), 11'(w)};
            frames = $urandom_range(1, 2);
            extra  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
            run_phase(do_w, wval, do_h, 13'(h), frames, extra, n);
            sent  += n;
            first  = 1'b0;
        end

        // Closing stretch at full rate, nobody idles.
        wait_idle();
        calm = 1'b1;
        run_phase(1'b1, 13'd6, 1'b1, 13'd4, 2, 0, n);
        wait_idle();

        mismatches += results_due.size();
        $display("Streamed %0d pixels and checked %0d edge results (%0d frame ends)",
                 pixels_taken, results_seen, frames_ended);
        $display("Small frames up to 40 wide, some sizes clamped up to 3; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
